// ----- design/sdt_pkg.sv -----
// Shared constants, codes and types of the security domain table.
package sdt_pkg;

	// Number of domain slots and the width of a slot index.
	localparam int unsigned DOMAIN_COUNT = 8;
	localparam int unsigned IDX_W        = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_CREATE    = 2'd0,
		REQ_DESTROY   = 2'd1,
		REQ_SET_LEVEL = 2'd2,
		REQ_CHECK     = 2'd3
	} req_e_t;

	// Level codes; the fourth code is not a level.
	localparam logic [1:0] LVL_PUBLIC    = 2'd0;
	localparam logic [1:0] LVL_PRIVATE   = 2'd1;
	localparam logic [1:0] LVL_SOVEREIGN = 2'd2;

	// Status codes returned with every item.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_SCRUB   = 3'd4;

	// One request item as held in the input register.
	typedef struct packed {
		req_e_t     req_type;
		logic [7:0] domain_id;
		logic [7:0] other_domain;
		logic [1:0] req_level;
		logic [7:0] owner;
	} req_t;

	// Decision for one request, handed from the table to the top level.
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] new_domain;
		logic       violation;
	} resp_t;

endpackage

// ----- design/sdt_table.sv -----
// Domain slot table with the request decision and its state updates.
module sdt_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enabled,
	input  logic          commit,
	input  sdt_pkg::req_t req,
	output sdt_pkg::resp_t resp
);
	import sdt_pkg::*;

	// Per-slot state.
	logic [DOMAIN_COUNT-1:0] active_q;
	logic [1:0]              level_q    [DOMAIN_COUNT];
	logic [7:0]              owner_q    [DOMAIN_COUNT];
	logic [DOMAIN_COUNT-1:0] isolated_q;

	logic [DOMAIN_COUNT-1:0] free;
	logic [DOMAIN_COUNT-1:0] lowest;
	logic [IDX_W-1:0]        slot;
	logic                    any_free;
	logic [IDX_W-1:0]        id_idx;
	logic [IDX_W-1:0]        oth_idx;
	logic                    id_live;
	logic                    oth_live;
	logic [1:0]              src_lvl;
	logic [1:0]              dst_lvl;
	logic                    lvl_ok;
	logic                    wr_create;
	logic                    wr_clear;
	logic                    wr_level;

	// Lowest free slot: isolate the lowest set bit, then encode it.
	always_comb begin
		free     = ~active_q;
		lowest   = free & (~free + DOMAIN_COUNT'(1));
		any_free = |free;
		slot     = '0;
		for (int i = 0; i < DOMAIN_COUNT; i++) begin
			if (lowest[i]) begin
				slot = slot | IDX_W'(i);
			end
		end
	end

	// Id lookups for both domains of the request.
	always_comb begin
		id_idx   = req.domain_id[IDX_W-1:0];
		oth_idx  = req.other_domain[IDX_W-1:0];
		id_live  = (req.domain_id < 8'(DOMAIN_COUNT)) && active_q[id_idx];
		oth_live = (req.other_domain < 8'(DOMAIN_COUNT)) && active_q[oth_idx];
		src_lvl  = level_q[id_idx];
		dst_lvl  = level_q[oth_idx];
		lvl_ok   = (req.req_level <= LVL_SOVEREIGN);
	end

	// Request decision.
	always_comb begin
		resp      = '{status: ST_INVALID, new_domain: 3'd0, violation: 1'b0};
		wr_create = 1'b0;
		wr_clear  = 1'b0;
		wr_level  = 1'b0;
		if (enabled) begin
			unique case (req.req_type)
				REQ_CREATE: begin
					if (lvl_ok) begin
						if (any_free) begin
							wr_create       = 1'b1;
							resp.status     = ST_OK;
							resp.new_domain = 3'(slot);
						end else begin
							resp.status = ST_NOSPACE;
						end
					end
				end
				REQ_DESTROY: begin
					if (id_live) begin
						wr_clear    = 1'b1;
						resp.status = ST_OK;
					end
				end
				REQ_SET_LEVEL: begin
					if (id_live && lvl_ok) begin
						// A sovereign domain may never be lowered.
						if (src_lvl == LVL_SOVEREIGN && req.req_level != LVL_SOVEREIGN) begin
							resp.status    = ST_BLOCKED;
							resp.violation = 1'b1;
						end else begin
							wr_level    = 1'b1;
							resp.status = ST_OK;
						end
					end
				end
				REQ_CHECK: begin
					if (id_live && oth_live) begin
						if (req.domain_id == req.other_domain) begin
							resp.status = ST_OK;
						end else if (src_lvl == LVL_SOVEREIGN && dst_lvl != LVL_SOVEREIGN) begin
							resp.status    = ST_BLOCKED;
							resp.violation = 1'b1;
						end else if (src_lvl == LVL_PRIVATE && dst_lvl == LVL_PUBLIC) begin
							resp.status = ST_SCRUB;
						end else begin
							resp.status = ST_OK;
						end
					end
				end
				default: begin
					resp.status = ST_INVALID;
				end
			endcase
		end
	end

	// Table updates; owner and isolation are kept as domain records.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			isolated_q <= '0;
			for (int i = 0; i < DOMAIN_COUNT; i++) begin
				level_q[i] <= LVL_PUBLIC;
				owner_q[i] <= 8'd0;
			end
		end else if (commit) begin
			if (wr_create) begin
				active_q[slot]   <= 1'b1;
				level_q[slot]    <= req.req_level;
				owner_q[slot]    <= req.owner;
				isolated_q[slot] <= (req.req_level == LVL_SOVEREIGN);
			end
			if (wr_clear) begin
				active_q[id_idx]   <= 1'b0;
				level_q[id_idx]    <= LVL_PUBLIC;
				owner_q[id_idx]    <= 8'd0;
				isolated_q[id_idx] <= 1'b0;
			end
			if (wr_level) begin
				level_q[id_idx] <= req.req_level;
				if (req.req_level == LVL_SOVEREIGN) begin
					isolated_q[id_idx] <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/security_domain_table.sv -----
// Top level of the security domain table: handshakes, counter and result register.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  req_type, domain_id, other_domain,
//                                            req_level, owner
//  res       output     res_valid/res_stall  status, new_domain, violation_total
//  cfg       input      cfg_valid/cfg_ready  cfg_data (enabled)
//
// One item is taken per cycle unless the input is stalled; its result passes
// the input register, the single table lookup stage, then the result register.
// Reset clears the table, the violation counter and the enable bit at once.
// A stall on the result side holds the result register and, in the same cycle,
// stalls the input once the input register is also full.
module security_domain_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  domain_id,
	input  logic [7:0]  other_domain,
	input  logic [1:0]  req_level,
	input  logic [7:0]  owner,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [2:0]  new_domain,
	output logic [31:0] violation_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import sdt_pkg::*;

	logic        enabled_q;
	logic        valid_s1;
	req_t        req_s1;
	logic        advance;
	logic        commit;
	resp_t       resp;
	logic [31:0] viol_q;
	logic [31:0] viol_next;
	logic        res_valid_q;
	logic [2:0]  status_q;
	logic [2:0]  new_domain_q;
	logic [31:0] total_q;

	// Configuration register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enabled_q <= cfg_data;
		end
	end

	// Flow control between input register and result register.
	assign advance  = !res_valid_q || !res_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= '{req_type: req_e_t'(req_type), domain_id: domain_id,
				other_domain: other_domain, req_level: req_level, owner: owner};
		end
	end

	sdt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.enabled (enabled_q),
		.commit  (commit),
		.req     (req_s1),
		.resp    (resp)
	);

	// Violation counter wraps at 32 bits.
	assign viol_next = viol_q + {31'd0, resp.violation};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viol_q <= 32'd0;
		end else if (commit) begin
			viol_q <= viol_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= resp.status;
			new_domain_q <= resp.new_domain;
			total_q      <= viol_next;
		end
	end

	assign res_valid       = res_valid_q;
	assign status          = status_q;
	assign new_domain      = new_domain_q;
	assign violation_total = total_q;

`ifndef NO_ASSERTIONS
	// The counter moves only when an item is committed.
	a_viol_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(viol_q))
		else $error("violation counter changed without a committed item");

	// A counted violation advances the counter by exactly one.
	a_viol_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && resp.violation |=> viol_q == $past(viol_q) + 32'd1)
		else $error("violation counter did not advance by one");

	// A disabled block answers invalid.
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !enabled_q |-> resp.status == ST_INVALID && !resp.violation)
		else $error("disabled block gave a non-invalid answer");

	// Only a successful create reports a slot.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		commit && resp.status != ST_OK |-> resp.new_domain == 3'd0)
		else $error("slot reported on a failed request");

	// The reported total matches the counter once the item is committed.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> total_q == viol_q)
		else $error("reported total differs from the counter");
`endif

endmodule
